FILE: hw/rtl/ring_fifo_with_unget_and_terminator_macros.svh
// Assertion macros used by the ring FIFO control module.
`ifndef RING_FIFO_WITH_UNGET_AND_TERMINATOR_MACROS_SVH
`define RING_FIFO_WITH_UNGET_AND_TERMINATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFUT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rfut_pkg.sv
package rfut_pkg;

    localparam int ITEM_W     = 9;
    localparam int DEPTH_DEF  = 256;
    localparam int OFFSET_W   = 8;
    localparam int FILL_W     = 8;
    localparam int MODE_W     = 2;
    localparam int REASON_W   = 2;
    localparam int TERM_EN_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    // Bit 8 of an item is its end mark.
    localparam int END_MARK_POS = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_UNGET = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SRC_NONE     = 2'd0,
        SRC_RING     = 2'd1,
        SRC_PUSHBACK = 2'd2
    } t_src;

    localparam logic [REASON_W-1:0] END_NONE = 2'd0;
    localparam logic [REASON_W-1:0] END_TERM = 2'd1;
    localparam logic [REASON_W-1:0] END_BIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TERM_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_VALUE  = 1'b1;

    typedef struct packed {
        logic [TERM_EN_W-1:0] term_enable;
        logic [ITEM_W-1:0]    term_value;
    } t_cfg;

    // Word waiting for the output stage: load is high in the cycle it is taken.
    typedef struct packed {
        logic              load;
        t_src              src;
        logic [ITEM_W-1:0] item;
        logic              check;
        logic              acc;
        logic [FILL_W-1:0] fill;
    } t_pend;

endpackage

FILE: hw/rtl/rfut_ram.sv
module rfut_ram #(
    parameter int WIDTH = rfut_pkg::ITEM_W,
    parameter int DEPTH = rfut_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rfut_ctrl.sv
`include "ring_fifo_with_unget_and_terminator_macros.svh"

module rfut_ctrl #(
    parameter int DEPTH = rfut_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rfut_pkg::MODE_W-1:0]   i_mode,
    input  logic [rfut_pkg::ITEM_W-1:0]   i_value,
    input  logic [rfut_pkg::OFFSET_W-1:0] i_offset,
    input  logic                          i_out_free,
    output rfut_pkg::t_pend               o_pend,
    output logic                          o_ram_we,
    output logic [$clog2(DEPTH)-1:0]      o_ram_waddr,
    output logic [rfut_pkg::ITEM_W-1:0]   o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(DEPTH)-1:0]      o_ram_raddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = (AW > rfut_pkg::FILL_W) ? AW : rfut_pkg::FILL_W;
    localparam int SW = ((AW > rfut_pkg::OFFSET_W) ? AW : rfut_pkg::OFFSET_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_rd, n_rd;
    logic [AW-1:0]               r_wr, n_wr;
    logic [AW-1:0]               r_fill, n_fill;
    logic                        r_pb_valid, n_pb_valid;
    logic [rfut_pkg::ITEM_W-1:0] r_pb_item, n_pb_item;
    rfut_pkg::t_src              r_p_src, n_p_src;
    logic [rfut_pkg::ITEM_W-1:0] r_p_item, n_p_item;
    logic                        r_p_check, n_p_check;
    logic                        r_p_acc, n_p_acc;
    logic [rfut_pkg::FILL_W-1:0] r_p_fill, n_p_fill;

    logic          in_acc;
    logic          full;
    logic          offset_hit;
    logic [AW-1:0] rd_next;
    logic [AW-1:0] wr_next;
    logic [SW-1:0] peek_sum;
    logic [SW-1:0] peek_wrap;
    logic [FW-1:0] fill_ext;

    assign in_acc     = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != ST_IDLE);
    assign full       = (r_fill == AW'(DEPTH - 1));
    assign offset_hit = (SW'(i_offset) < SW'(r_fill));
    assign rd_next    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    assign wr_next    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);

    // The offset is below the fill level whenever it is used, so one wrap suffices.
    assign peek_sum  = SW'(r_rd) + SW'(i_offset);
    assign peek_wrap = (peek_sum >= SW'(DEPTH)) ? peek_sum - SW'(DEPTH) : peek_sum;
    assign fill_ext  = FW'(n_fill);

    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_fill      = r_fill;
        n_pb_valid  = r_pb_valid;
        n_pb_item   = r_pb_item;
        n_p_src     = r_p_src;
        n_p_item    = r_p_item;
        n_p_check   = r_p_check;
        n_p_acc     = r_p_acc;
        n_p_fill    = r_p_fill;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state   = ST_LOAD;
                    n_p_src   = rfut_pkg::SRC_NONE;
                    n_p_item  = r_pb_item;
                    n_p_check = 1'b0;
                    n_p_acc   = 1'b0;
                    case (rfut_pkg::t_mode'(i_mode))
                        rfut_pkg::MODE_PUSH: begin
                            if (!full) begin
                                o_ram_we = 1'b1;
                                n_wr     = wr_next;
                                n_fill   = r_fill + AW'(1);
                                n_p_acc  = 1'b1;
                            end
                        end
                        rfut_pkg::MODE_POP: begin
                            if (r_pb_valid) begin
                                n_pb_valid = 1'b0;
                                n_p_src    = rfut_pkg::SRC_PUSHBACK;
                                n_p_acc    = 1'b1;
                            end else if (r_fill != '0) begin
                                o_ram_re  = 1'b1;
                                n_rd      = rd_next;
                                n_fill    = r_fill - AW'(1);
                                n_p_src   = rfut_pkg::SRC_RING;
                                n_p_check = 1'b1;
                                n_p_acc   = 1'b1;
                            end
                        end
                        rfut_pkg::MODE_PEEK: begin
                            if (offset_hit) begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = peek_wrap[AW-1:0];
                                n_p_src     = rfut_pkg::SRC_RING;
                                n_p_acc     = 1'b1;
                            end
                        end
                        rfut_pkg::MODE_UNGET: begin
                            if (!r_pb_valid) begin
                                n_pb_valid = 1'b1;
                                n_pb_item  = i_value;
                                n_p_acc    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_p_fill = fill_ext[rfut_pkg::FILL_W-1:0];
                end
            end
            ST_LOAD: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd       <= AW'(1);
            r_wr       <= AW'(1);
            r_fill     <= '0;
            r_pb_valid <= 1'b0;
            r_pb_item  <= '0;
        end else begin
            r_state    <= n_state;
            r_rd       <= n_rd;
            r_wr       <= n_wr;
            r_fill     <= n_fill;
            r_pb_valid <= n_pb_valid;
            r_pb_item  <= n_pb_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_src   <= n_p_src;
        r_p_item  <= n_p_item;
        r_p_check <= n_p_check;
        r_p_acc   <= n_p_acc;
        r_p_fill  <= n_p_fill;
    end

    assign o_ram_waddr = r_wr;
    assign o_ram_wdata = i_value;

    assign o_pend = '{
        load:  (r_state == ST_LOAD) && i_out_free,
        src:   r_p_src,
        item:  r_p_item,
        check: r_p_check,
        acc:   r_p_acc,
        fill:  r_p_fill
    };

    `RFUT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= AW'(DEPTH - 1), "fill over capacity")
    `RFUT_ASSERT_NOW(a_ram_one_port, i_clk, i_rst_n, o_ram_we, !o_ram_re, "ram read and write together")
    `RFUT_ASSERT_NEXT(a_accept_load, i_clk, i_rst_n, in_acc, r_state == ST_LOAD, "accept without load")
    `RFUT_ASSERT_NEXT(a_full_push, i_clk, i_rst_n, in_acc && full && (i_mode == rfut_pkg::MODE_PUSH), $stable(r_fill), "full push moved fill")

endmodule

FILE: hw/rtl/rfut_out.sv
module rfut_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rfut_pkg::t_pend               i_pend,
    input  logic [rfut_pkg::ITEM_W-1:0]   i_rdata,
    input  rfut_pkg::t_cfg                i_cfg,
    input  logic                          i_out_stall,
    output logic                          o_free,
    output logic                          o_out_valid,
    output logic [rfut_pkg::ITEM_W-1:0]   o_data,
    output logic                          o_data_valid,
    output logic                          o_accepted,
    output logic [rfut_pkg::REASON_W-1:0] o_end_reason,
    output logic [rfut_pkg::FILL_W-1:0]   o_fill_level
);

    logic                          r_out_valid;
    logic [rfut_pkg::ITEM_W-1:0]   r_data, n_data;
    logic                          r_data_valid, n_data_valid;
    logic                          r_accepted;
    logic [rfut_pkg::REASON_W-1:0] r_end_reason, n_end_reason;
    logic [rfut_pkg::FILL_W-1:0]   r_fill_level;

    assign o_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_data       = '0;
        n_data_valid = 1'b0;
        case (i_pend.src)
            rfut_pkg::SRC_RING: begin
                n_data       = i_rdata;
                n_data_valid = 1'b1;
            end
            rfut_pkg::SRC_PUSHBACK: begin
                n_data       = i_pend.item;
                n_data_valid = 1'b1;
            end
            default: begin
            end
        endcase
        // A value match takes precedence over the end mark.
        n_end_reason = rfut_pkg::END_NONE;
        if (i_pend.check) begin
            if (i_cfg.term_enable[0] && (i_rdata == i_cfg.term_value)) begin
                n_end_reason = rfut_pkg::END_TERM;
            end else if (i_cfg.term_enable[1] && i_rdata[rfut_pkg::END_MARK_POS]) begin
                n_end_reason = rfut_pkg::END_BIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_pend.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pend.load) begin
            r_data       <= n_data;
            r_data_valid <= n_data_valid;
            r_accepted   <= i_pend.acc;
            r_end_reason <= n_end_reason;
            r_fill_level <= i_pend.fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_data;
    assign o_data_valid = r_data_valid;
    assign o_accepted   = r_accepted;
    assign o_end_reason = r_end_reason;
    assign o_fill_level = r_fill_level;

endmodule

FILE: hw/rtl/ring_fifo_with_unget_and_terminator.sv
// Path: an input word is taken in the idle state, any ring memory read is registered as
// the control enters the load state, and the result is loaded into the output register
// once that is free; input stalls until then, so a stalled output holds the next word off.
// Reset is synchronous, active low: pointers go to one; fill count, pushed-back word and
// the terminator registers clear at once; the ring memory is not cleared and needs no sweep.
module ring_fifo_with_unget_and_terminator #(
    parameter int DEPTH = rfut_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rfut_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfut_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rfut_pkg::MODE_W-1:0]     i_mode,
    input  logic [rfut_pkg::ITEM_W-1:0]     i_value,
    input  logic [rfut_pkg::OFFSET_W-1:0]   i_offset,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rfut_pkg::ITEM_W-1:0]     o_data,
    output logic                            o_data_valid,
    output logic                            o_accepted,
    output logic [rfut_pkg::REASON_W-1:0]   o_end_reason,
    output logic [rfut_pkg::FILL_W-1:0]     o_fill_level
);

    localparam int AW = $clog2(DEPTH);

    rfut_pkg::t_cfg              r_cfg;
    rfut_pkg::t_pend             pend;
    logic                        out_free;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [rfut_pkg::ITEM_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [rfut_pkg::ITEM_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rfut_pkg::CFG_TERM_ENABLE: begin
                    r_cfg.term_enable <= i_cfg_data[rfut_pkg::TERM_EN_W-1:0];
                end
                rfut_pkg::CFG_TERM_VALUE: begin
                    r_cfg.term_value <= i_cfg_data[rfut_pkg::ITEM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rfut_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .i_offset    (i_offset),
        .i_out_free  (out_free),
        .o_pend      (pend),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    rfut_ram #(
        .WIDTH (rfut_pkg::ITEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rfut_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pend       (pend),
        .i_rdata      (ram_rdata),
        .i_cfg        (r_cfg),
        .i_out_stall  (i_out_stall),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_accepted   (o_accepted),
        .o_end_reason (o_end_reason),
        .o_fill_level (o_fill_level)
    );

endmodule
